@@ design/cfbl_pkg.sv @@
// types, constants and helpers shared by the chunked free block list files
package cfbl_pkg;

   localparam int BLK_W  = 10;
   localparam int CNT_W  = 11;
   localparam int FILL_W = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   typedef enum logic {
      FUNC_FREE  = 1'b0,
      FUNC_ALLOC = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OUTSIDE   = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_BAD_ALLOC = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_DATA_ZONE = 1'b0,
      CSR_ZONE_COUNT      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic [BLK_W-1:0]  link;
   } meta_type;

   function automatic logic in_zone(input logic [BLK_W-1:0] blk,
                                    input logic [BLK_W-1:0] first,
                                    input logic [CNT_W-1:0] count);
      logic lo_ok;
      logic hi_ok;
      lo_ok = (blk >= first);
      hi_ok = ({1'b0, blk} < count);
      return lo_ok && hi_ok;
   endfunction

endpackage

@@ design/cfbl_ram.sv @@
// generic simple dual-port ram with registered read
module cfbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/chunked_free_block_list.sv @@
// top level of the chunked free block list allocator
// An item is taken only while the block is idle. At acceptance the head chunk's fill count
// and link are read from the metadata memory. A free, an allocate on an empty list or an
// allocate that hands out the head block itself has its result registered in ST_EXEC, and
// the input takes no new item until the block is back in ST_IDLE. An allocate that pops a
// slot out of the head chunk reads the slot memory in an extra state, ST_POP: its result is
// registered there, and the next item is taken only after that. While rsp_stall holds a
// result the next item is still taken, but it waits in its last step until the held result
// leaves. Configuration writes are always taken (csr_ready stays high). The chunk memories
// need no clearing pass after reset.
module chunked_free_block_list
   import cfbl_pkg::*;
#(
   parameter int NUM_BLOCKS  = 1024,
   parameter int CHUNK_SLOTS = 254
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [BLK_W-1:0]      req_block_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BLK_W-1:0]      rsp_allocated_block,
   output logic [1:0]            rsp_status,
   output logic [CNT_W-1:0]      rsp_free_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int BLK_AW     = $clog2(NUM_BLOCKS);
   localparam int SLOT_DEPTH = NUM_BLOCKS * CHUNK_SLOTS;
   localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
   localparam logic [FILL_W-1:0] SLOTS_FILL = FILL_W'(CHUNK_SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP
   } state_type;

   state_type           state_ff,  state_in;
   logic [BLK_W-1:0]    first_zone_ff, first_zone_in;
   logic [CNT_W-1:0]    zone_count_ff, zone_count_in;
   logic                head_valid_ff, head_valid_in;
   logic [BLK_W-1:0]    head_block_ff, head_block_in;
   logic [CNT_W-1:0]    free_total_ff, free_total_in;
   logic                func_ff, func_in;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]    rsp_block_ff, rsp_block_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                meta_we;
   logic [BLK_AW-1:0]   meta_waddr;
   meta_type            meta_wdata;
   logic                meta_re;
   meta_type            meta_rdata;
   logic                slot_we;
   logic                slot_re;
   logic [SLOT_AW-1:0]  slot_waddr;
   logic [SLOT_AW-1:0]  slot_raddr;
   logic [BLK_W-1:0]    slot_rdata;

   logic                accept;
   logic                out_free;
   logic                head_in_store;
   logic                blk_in_store;
   logic [FILL_W-1:0]   fill_raw;
   logic [FILL_W-1:0]   fill_cap;
   logic [FILL_W-1:0]   fill_dec;
   logic [BLK_W-1:0]    link_raw;
   logic [SLOT_AW-1:0]  slot_base;
   logic [CNT_W-1:0]    count_inc;
   logic [CNT_W-1:0]    count_dec;
   logic [BLK_W-1:0]    given;
   logic                given_ok;

   cfbl_ram #(
      .WIDTH ($bits(meta_type)),
      .DEPTH (NUM_BLOCKS)
   ) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (meta_waddr),
      .wdata (meta_wdata),
      .re    (meta_re),
      .raddr (BLK_AW'(head_block_ff)),
      .rdata (meta_rdata)
   );

   cfbl_ram #(
      .WIDTH (BLK_W),
      .DEPTH (SLOT_DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (blk_ff),
      .re    (slot_re),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign head_in_store = (int'(head_block_ff) < NUM_BLOCKS);
   assign blk_in_store  = (int'(blk_ff) < NUM_BLOCKS);
   assign fill_raw = head_in_store ? meta_rdata.fill : '0;
   assign link_raw = head_in_store ? meta_rdata.link : '0;
   assign fill_cap = (fill_raw > SLOTS_FILL) ? SLOTS_FILL : fill_raw;
   assign fill_dec = fill_cap - FILL_W'(1);
   assign slot_base  = SLOT_AW'(head_block_ff) * SLOT_AW'(CHUNK_SLOTS);
   assign slot_waddr = slot_base + SLOT_AW'(fill_raw);
   assign slot_raddr = slot_base + SLOT_AW'(fill_dec);
   assign count_inc = (free_total_ff != {CNT_W{1'b1}}) ? free_total_ff + CNT_W'(1)
                                                      : free_total_ff;
   assign count_dec = (free_total_ff != '0) ? free_total_ff - CNT_W'(1) : free_total_ff;
   assign given    = (state_ff == ST_POP) ? slot_rdata : head_block_ff;
   assign given_ok = in_zone(given, first_zone_ff, zone_count_ff);

   always_comb begin
      state_in      = state_ff;
      first_zone_in = first_zone_ff;
      zone_count_in = zone_count_ff;
      head_valid_in = head_valid_ff;
      head_block_in = head_block_ff;
      free_total_in = free_total_ff;
      func_in       = func_ff;
      blk_in        = blk_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_block_in  = rsp_block_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      meta_we       = 1'b0;
      meta_waddr    = BLK_AW'(head_block_ff);
      meta_wdata    = '{fill: fill_dec, link: link_raw};
      meta_re       = 1'b0;
      slot_we       = 1'b0;
      slot_re       = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_DATA_ZONE: first_zone_in = csr_wdata[BLK_W-1:0];
            CSR_ZONE_COUNT:      zone_count_in = csr_wdata[CNT_W-1:0];
            default:             ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               meta_re  = 1'b1;
               func_in  = req_func;
               blk_in   = req_block_number;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (func_ff == FUNC_FREE) begin
               if (out_free) begin
                  rsp_block_in = '0;
                  if (!in_zone(blk_ff, first_zone_ff, zone_count_ff)) begin
                     rsp_status_in = STATUS_OUTSIDE;
                  end else begin
                     rsp_status_in = STATUS_OK;
                     free_total_in = count_inc;
                     if (!head_valid_ff || fill_raw >= SLOTS_FILL) begin
                        // freed block opens a new head chunk
                        meta_we       = blk_in_store;
                        meta_waddr    = BLK_AW'(blk_ff);
                        meta_wdata    = '{fill: '0, link: head_valid_ff ? head_block_ff : '0};
                        head_block_in = blk_ff;
                        head_valid_in = 1'b1;
                     end else begin
                        slot_we    = head_in_store;
                        meta_we    = head_in_store;
                        meta_wdata = '{fill: fill_raw + FILL_W'(1), link: link_raw};
                     end
                  end
                  rsp_count_in = free_total_in;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (!head_valid_ff) begin
               if (out_free) begin
                  rsp_block_in  = '0;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_count_in  = free_total_ff;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (fill_cap != '0) begin
               // pop the last slot of the head chunk
               meta_we  = head_in_store;
               slot_re  = 1'b1;
               state_in = ST_POP;
            end else if (out_free) begin
               // hand out the empty head chunk itself
               head_block_in = link_raw;
               head_valid_in = (link_raw != '0);
               rsp_block_in  = given;
               if (given_ok) begin
                  rsp_status_in = STATUS_OK;
                  free_total_in = count_dec;
               end else begin
                  rsp_status_in = STATUS_BAD_ALLOC;
               end
               rsp_count_in = free_total_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_POP: begin
            if (out_free) begin
               rsp_block_in = given;
               if (given_ok) begin
                  rsp_status_in = STATUS_OK;
                  free_total_in = count_dec;
               end else begin
                  rsp_status_in = STATUS_BAD_ALLOC;
               end
               rsp_count_in = free_total_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_zone_ff <= BLK_W'(1);
         zone_count_ff <= CNT_W'(1024);
         head_valid_ff <= 1'b0;
         head_block_ff <= '0;
         free_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_zone_ff <= first_zone_in;
         zone_count_ff <= zone_count_in;
         head_valid_ff <= head_valid_in;
         head_block_ff <= head_block_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff       <= func_in;
      blk_ff        <= blk_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_block_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_free_count      = rsp_count_ff;

endmodule

@@ design/cfbl_checker.sv @@
// port-level checks for the chunked free block list, bound to the top level
module cfbl_checker
   import cfbl_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [BLK_W-1:0]      rsp_allocated_block,
   input logic [1:0]            rsp_status,
   input logic [CNT_W-1:0]      rsp_free_count
);

   logic [CNT_W-1:0] last_count_ff;
   logic             rsp_take;
   logic [CNT_W:0]   cur_ext;
   logic [CNT_W:0]   last_ext;

   assign rsp_take = rsp_valid && !rsp_stall;
   assign cur_ext  = {1'b0, rsp_free_count};
   assign last_ext = {1'b0, last_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
      end else if (rsp_take) begin
         last_count_ff <= rsp_free_count;
      end
   end

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_allocated_block)
         && $stable(rsp_status) && $stable(rsp_free_count))
      else $error("stalled result changed");

   // an accepted item blocks the input in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken in back-to-back cycles");

   // ignored frees and empty allocates leave the free count alone
   assert property (@(posedge clock) disable iff (reset)
      rsp_take && (rsp_status == STATUS_OUTSIDE || rsp_status == STATUS_EMPTY)
         |-> rsp_free_count == last_count_ff)
      else $error("free count moved on a no-op item");

   // the free count moves by at most one per item
   assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (cur_ext == last_ext || cur_ext == last_ext + 1'b1
         || cur_ext + 1'b1 == last_ext))
      else $error("free count jumped");

endmodule

bind chunked_free_block_list cfbl_checker u_cfbl_checker (.*);
